FILE: hdl/hsv_to_rgb_converter_macros.svh
// ----------------------------------------------------------------------------
// HSV to RGB converter assertion macros
// Concurrent assertion wrappers; they expand to nothing when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

`ifndef SYNTH
// checked outside reset only
`define H2R_ASSERT(lbl, clk_, rst_, prop, msg) \
  lbl: assert property (@(posedge clk_) disable iff (rst_) prop) else $error(msg);
// checked at every edge, reset included
`define H2R_ASSERT_ALWAYS(lbl, clk_, prop, msg) \
  lbl: assert property (@(posedge clk_) prop) else $error(msg);
`else
`define H2R_ASSERT(lbl, clk_, rst_, prop, msg)
`define H2R_ASSERT_ALWAYS(lbl, clk_, prop, msg)
`endif

`endif

FILE: hdl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field widths, fixed-point constants and sector decode helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package h2r_pkg;

  localparam int unsigned HUE_W       = 9;
  localparam int unsigned PCT_W       = 7;
  localparam int unsigned CH_W        = 8;
  localparam int unsigned SEC_W       = 3;
  localparam int unsigned FRAC_W      = 6;
  localparam int unsigned TERM_W      = 13;  // 6000 - S*k, at most 6000
  localparam int unsigned PROD_W      = 20;  // B*term, at most 600000
  localparam int unsigned SUM_W       = 28;  // 255*B*term + 300000
  localparam int unsigned DIV_PRESHIFT = 6;  // 600000 = 2^6 * 9375
  localparam int unsigned QUO_W       = SUM_W - DIV_PRESHIFT;
  localparam int unsigned RECIP_W     = 23;
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned MUL_W       = QUO_W + RECIP_W;

  localparam logic [HUE_W-1:0]   HUE_WRAP   = 9'd360;
  localparam logic [HUE_W-1:0]   SEC_SPAN   = 9'd60;
  localparam logic [PCT_W-1:0]   PCT_MAX    = 7'd100;
  localparam logic [FRAC_W-1:0]  FRAC_FULL  = 6'd60;
  localparam logic [TERM_W-1:0]  TERM_FULL  = 13'd6000;
  localparam logic [SUM_W-1:0]   ROUND_BIAS = 28'd300000;
  // ceil(2^36 / 9375); exact floor division for quotients below 2^22
  localparam logic [RECIP_W-1:0] RECIP      = 23'd7330078;

  // channel roles within a sector
  localparam logic [1:0] ROLE_LEAD  = 2'd0;
  localparam logic [1:0] ROLE_FLOOR = 2'd1;
  localparam logic [1:0] ROLE_FALL  = 2'd2;
  localparam logic [1:0] ROLE_RISE  = 2'd3;

  typedef logic [HUE_W-1:0]  hue_t;
  typedef logic [PCT_W-1:0]  pct_t;
  typedef logic [CH_W-1:0]   chan_t;
  typedef logic [FRAC_W-1:0] frac_t;
  typedef logic [SEC_W-1:0]  sec_t;
  typedef logic [TERM_W-1:0] term_t;

  // index 0 red, 1 green, 2 blue
  typedef logic [2:0][1:0] roles_t;

  typedef struct packed {
    sec_t  sec;
    frac_t frac;
  } sector_t;

  // hue already below 360
  function automatic sector_t sector_split(hue_t h);
    sector_t res;
    hue_t    base;
    if (h >= 5 * SEC_SPAN) begin
      res.sec = 3'd5; base = hue_t'(5 * SEC_SPAN);
    end else if (h >= 4 * SEC_SPAN) begin
      res.sec = 3'd4; base = hue_t'(4 * SEC_SPAN);
    end else if (h >= 3 * SEC_SPAN) begin
      res.sec = 3'd3; base = hue_t'(3 * SEC_SPAN);
    end else if (h >= 2 * SEC_SPAN) begin
      res.sec = 3'd2; base = hue_t'(2 * SEC_SPAN);
    end else if (h >= SEC_SPAN) begin
      res.sec = 3'd1; base = SEC_SPAN;
    end else begin
      res.sec = 3'd0; base = '0;
    end
    res.frac = FRAC_W'(h - base);
    return res;
  endfunction

  function automatic roles_t sector_roles(sec_t sec);
    roles_t r;
    case (sec)
      3'd0:    r = {ROLE_FLOOR, ROLE_RISE,  ROLE_LEAD};
      3'd1:    r = {ROLE_FLOOR, ROLE_LEAD,  ROLE_FALL};
      3'd2:    r = {ROLE_RISE,  ROLE_LEAD,  ROLE_FLOOR};
      3'd3:    r = {ROLE_LEAD,  ROLE_FALL,  ROLE_FLOOR};
      3'd4:    r = {ROLE_LEAD,  ROLE_FLOOR, ROLE_RISE};
      default: r = {ROLE_FALL,  ROLE_FLOOR, ROLE_LEAD};
    endcase
    return r;
  endfunction

  function automatic frac_t role_k(logic [1:0] role, frac_t frac);
    frac_t k;
    case (role)
      ROLE_LEAD:  k = '0;
      ROLE_FLOOR: k = FRAC_FULL;
      ROLE_FALL:  k = frac;
      ROLE_RISE:  k = FRAC_FULL - frac;
      default:    k = '0;
    endcase
    return k;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/hsv_to_rgb_converter.sv
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-stage pipeline from hue/saturation/brightness to 8-bit red/green/blue.
// ----------------------------------------------------------------------------
//  channel   dir  tdata fields (lsb first)
//  s_axis    in   hue_degrees[8:0] saturation_pct[15:9] brightness_pct[22:16]
//  m_axis    out  red[7:0] green[15:8] blue[23:16]
//
//  One pixel per cycle sustained while m_tready stays high; an input transfer
//  reaches output valid through the stage chain wrap/clamp, sector split, S*k
//  term, B*term product, rounding sum and reciprocal multiply.
//  rst (synchronous) clears the stage valid bits only.
//  Each stage advances when it is empty or the stage after it advances, so
//  a stall fills bubbles first and then holds every stage in place.
// ----------------------------------------------------------------------------
`default_nettype none

`include "hsv_to_rgb_converter_macros.svh"

module hsv_to_rgb_converter
  import h2r_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // hue_degrees, saturation_pct, brightness_pct
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata    // red, green, blue
);

  localparam int unsigned NSTG = 6;

  logic [NSTG-1:0] vld;
  logic [NSTG-1:0] adv;

  always_comb begin
    adv[NSTG-1] = !vld[NSTG-1] || m_tready;
    for (int i = NSTG - 2; i >= 0; i--) begin
      adv[i] = !vld[i] || adv[i+1];
    end
  end

  assign s_tready = adv[0];
  assign m_tvalid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) begin
        vld[0] <= s_tvalid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // stage 0: wrap hue, clamp percentages
  hue_t in_hue;
  pct_t in_sat;
  pct_t in_bri;
  hue_t hue0;
  pct_t sat0;
  pct_t bri0;

  assign in_hue = s_tdata[8:0];
  assign in_sat = s_tdata[15:9];
  assign in_bri = s_tdata[22:16];

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      hue0 <= (in_hue >= HUE_WRAP) ? in_hue - HUE_WRAP : in_hue;
      sat0 <= (in_sat > PCT_MAX) ? PCT_MAX : in_sat;
      bri0 <= (in_bri > PCT_MAX) ? PCT_MAX : in_bri;
    end
  end

  // stage 1: sector and fraction
  sector_t sec1;
  pct_t    sat1;
  pct_t    bri1;

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      sec1 <= sector_split(hue0);
      sat1 <= sat0;
      bri1 <= bri0;
    end
  end

  // stage 2: per-channel term 6000 - S*k
  roles_t          roles1;
  term_t [2:0]     term_next;
  term_t [2:0]     term2;
  pct_t            bri2;

  assign roles1 = sector_roles(sec1.sec);

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      term_next[c] = TERM_FULL - TERM_W'(sat1) * TERM_W'(role_k(roles1[c], sec1.frac));
    end
  end

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      term2 <= term_next;
      bri2  <= bri1;
    end
  end

  // stage 3: B * term
  logic [2:0][PROD_W-1:0] prod3;

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      for (int c = 0; c < 3; c++) begin
        prod3[c] <= PROD_W'(bri2) * PROD_W'(term2[c]);
      end
    end
  end

  // stage 4: 255*p + half divisor, drop the power-of-two part of 600000
  logic [2:0][SUM_W-1:0] sum_next;
  logic [2:0][QUO_W-1:0] quo4;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      sum_next[c] = (SUM_W'(prod3[c]) << CH_W) - SUM_W'(prod3[c]) + ROUND_BIAS;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      for (int c = 0; c < 3; c++) begin
        quo4[c] <= sum_next[c][SUM_W-1:DIV_PRESHIFT];
      end
    end
  end

  // stage 5: divide by 9375 through the reciprocal
  logic [2:0][MUL_W-1:0] mul_next;
  chan_t [2:0]           chan5;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mul_next[c] = MUL_W'(quo4[c]) * MUL_W'(RECIP);
    end
  end

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      for (int c = 0; c < 3; c++) begin
        chan5[c] <= mul_next[c][RECIP_SHIFT +: CH_W];
      end
    end
  end

  assign m_tdata = {chan5[2], chan5[1], chan5[0]};

  `H2R_ASSERT(a_ready_on_drain, clk, rst, m_tready |-> s_tready, "input stalled while output drains")
  `H2R_ASSERT(a_ready_on_bubble, clk, rst, !vld[0] |-> s_tready, "input stalled with empty first stage")
  `H2R_ASSERT(a_accept_loads, clk, rst, (s_tvalid && s_tready) |=> vld[0], "accepted pixel lost at first stage")
  `H2R_ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !m_tvalid, "output valid right after reset")

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Streams hue/saturation/brightness pixels through the converter with random
// gaps on both sides. A scoreboard predicts red/green/blue for every
// accepted pixel and compares each output transfer against the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------

module tb_top;
  import h2r_pkg::*;

  localparam int unsigned RANDOM_PIXELS = 650;
  localparam int unsigned DRAIN_AT      = 325;
  localparam int unsigned IDLE_LIMIT    = 2000;
  localparam int unsigned TAIL_CYCLES   = 20;
  localparam int unsigned REPORT_MAX    = 10;

  class rgb_scoreboard;
    logic [23:0] rgb_q[$];
    int unsigned errors;

    function chan_t channel_level(int unsigned bri, int unsigned sat, int unsigned k);
      int unsigned num;
      num = 255 * bri * (6000 - sat * k);
      return chan_t'((num + 300000) / 600000);
    endfunction

    function logic [23:0] predict_rgb(logic [23:0] pix);
      int unsigned hue, sat, bri, sector, frac;
      chan_t lead, flr, fall, rise, r, g, b;
      hue = pix[8:0] % 360;
      sat = pix[15:9];
      bri = pix[22:16];
      if (sat > PCT_MAX) sat = PCT_MAX;
      if (bri > PCT_MAX) bri = PCT_MAX;
      sector = hue / 60;
      frac   = hue % 60;
      lead = channel_level(bri, sat, 0);
      flr  = channel_level(bri, sat, 60);
      fall = channel_level(bri, sat, frac);
      rise = channel_level(bri, sat, 60 - frac);
      case (sector)
        0: begin r = lead; g = rise; b = flr;  end
        1: begin r = fall; g = lead; b = flr;  end
        2: begin r = flr;  g = lead; b = rise; end
        3: begin r = flr;  g = fall; b = lead; end
        4: begin r = rise; g = flr;  b = lead; end
        default: begin r = lead; g = flr; b = fall; end
      endcase
      return {b, g, r};
    endfunction

    function void note_pixel(logic [23:0] pix);
      rgb_q.push_back(predict_rgb(pix));
    endfunction

    function void check_pixel(logic [23:0] rgb);
      logic [23:0] exp_rgb;
      if (rgb_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("unexpected output transfer rgb=%0d/%0d/%0d",
                   rgb[7:0], rgb[15:8], rgb[23:16]);
        return;
      end
      exp_rgb = rgb_q.pop_front();
      if (rgb[7:0] !== exp_rgb[7:0] || rgb[15:8] !== exp_rgb[15:8] ||
          rgb[23:16] !== exp_rgb[23:16]) begin
        errors++;
        if (errors <= REPORT_MAX)
          $display("rgb mismatch: expected %0d/%0d/%0d got %0d/%0d/%0d",
                   exp_rgb[7:0], exp_rgb[15:8], exp_rgb[23:16],
                   rgb[7:0], rgb[15:8], rgb[23:16]);
      end
    endfunction

    function int pending();
      return rgb_q.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata = '0;   // hue_degrees[8:0], saturation_pct[15:9], brightness_pct[22:16]
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;        // red[7:0], green[15:8], blue[23:16]

  rgb_scoreboard rgb_sb = new();
  bit          tx_calm;
  int unsigned idle_cycles;

  hsv_to_rgb_converter u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap(bit calm);
    int unsigned roll;
    if (calm) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic pct_t pick_pct();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll == 0) return '0;
    if (roll == 1) return pct_t'($urandom_range(100, 127));
    return pct_t'($urandom_range(0, 127));
  endfunction

  // entered and left at a falling edge
  task automatic send_pixel(int unsigned hue, int unsigned sat, int unsigned bri);
    int unsigned gap;
    gap = pick_gap(tx_calm);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tdata  <= {1'b0, pct_t'(bri), pct_t'(sat), hue_t'(hue)};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    while (rgb_sb.pending() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready) rgb_sb.note_pixel(s_tdata);
    if (!rst && m_tvalid && m_tready) rgb_sb.check_pixel(m_tdata);
  end

  // output backpressure with calm stretches
  initial begin
    int unsigned stall_left;
    int unsigned rx_cycle;
    stall_left = 0;
    rx_cycle = 0;
    forever begin
      @(negedge clk);
      rx_cycle++;
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready <= 1'b1;
        if ((rx_cycle % 400) >= 100 && $urandom_range(0, 99) < 25)
          stall_left = pick_gap(1'b0);
      end
    end
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    tx_calm = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // sector edges at full saturation and brightness
    send_pixel(0, 100, 100);
    send_pixel(59, 100, 100);
    send_pixel(60, 100, 100);
    send_pixel(119, 100, 100);
    send_pixel(120, 100, 100);
    send_pixel(179, 100, 100);
    send_pixel(180, 100, 100);
    send_pixel(239, 100, 100);
    send_pixel(240, 100, 100);
    send_pixel(299, 100, 100);
    send_pixel(300, 100, 100);
    send_pixel(359, 100, 100);
    // hue wrap and percent clamp
    send_pixel(360, 100, 100);
    send_pixel(511, 127, 127);
    send_pixel(419, 101, 101);
    // gray levels and black, then assorted saturation and brightness mixes
    send_pixel(200, 0, 100);
    send_pixel(200, 0, 50);
    send_pixel(75, 0, 127);
    send_pixel(0, 0, 0);
    send_pixel(90, 50, 0);
    send_pixel(30, 127, 100);
    send_pixel(150, 100, 1);
    send_pixel(210, 1, 100);
    send_pixel(270, 99, 99);
    send_pixel(330, 100, 127);

    for (int unsigned i = 0; i < RANDOM_PIXELS; i++) begin
      tx_calm = (i % 160) < 40;
      if (i == DRAIN_AT) begin
        // hold off until the pipeline has emptied
        s_tvalid <= 1'b0;
        wait_drained();
        @(negedge clk);
      end
      send_pixel($urandom_range(0, 511), pick_pct(), pick_pct());
    end
    s_tvalid <= 1'b0;

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (rgb_sb.errors == 0 && rgb_sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
